[hw/rtl/qrs_pkg.sv]
// Package for the quadratic root solver: widths, status codes and pipeline payload types.
package qrs_pkg;

	localparam int COEF_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int ROOT_W    = 35;

	localparam int SQ_STEPS = COEF_BITS + 2 + FRAC_BITS;
	localparam int REM_W    = SQ_STEPS + 2;
	localparam int RAD_W    = 2 * SQ_STEPS;
	localparam int DISC_W   = 2 * COEF_BITS + 2;
	localparam int NUM_W    = SQ_STEPS + 2;
	localparam int DEN_W    = COEF_BITS + 1;
	localparam int CMP_W    = ((NUM_W > ROOT_W) ? NUM_W : ROOT_W) + 1;

	typedef enum logic [1:0] {
		ST_REAL  = 2'd0,
		ST_IMAG  = 2'd1,
		ST_AZERO = 2'd2
	} status_t;

	typedef struct packed {
		status_t                       status;
		logic                          a_neg;
		logic [DEN_W-1:0]              den;
		logic signed [COEF_BITS-1:0]   b;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [SQ_STEPS-1:0] root;
		logic [RAD_W-1:0]    rad;
		side_t               side;
	} sq_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] acc;
	} lane_t;

	typedef struct packed {
		status_t          status;
		logic [DEN_W-1:0] den;
		logic             neg_p;
		logic             neg_m;
		lane_t            lp;
		lane_t            lm;
	} dv_t;

endpackage

[hw/rtl/qrs_in_if.sv]
// Coefficient input channel of the quadratic root solver.
interface qrs_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [qrs_pkg::COEF_BITS-1:0]    coef_a;
	logic signed [qrs_pkg::COEF_BITS-1:0]    coef_b;
	logic signed [qrs_pkg::COEF_BITS-1:0]    coef_c;

	modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

[hw/rtl/qrs_out_if.sv]
// Root result channel of the quadratic root solver.
interface qrs_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic signed [qrs_pkg::ROOT_W-1:0]    root_plus;
	logic signed [qrs_pkg::ROOT_W-1:0]    root_minus;

	modport source(output valid, output status, output root_plus, output root_minus, input ready);
	modport sink(input valid, input status, input root_plus, input root_minus, output ready);
endinterface

[hw/rtl/quadratic_root_solver.sv]
// Quadratic root solver top level: discriminant, square root chain, divider chain, output.
// Throughput: one coefficient set per cycle while the result is not stalled; all stages advance on one shared enable.
// Each square root digit and each quotient bit is one cell, so the chain lengths set latency.
// A stalled result holds the whole chain until its transfer.
// Reset clears all valid bits; payload registers are not reset.
module quadratic_root_solver (
	input  logic          clk,
	input  logic          arst_n,
	qrs_in_if.sink        coef_in,
	qrs_out_if.source     root_out
);

	localparam logic [qrs_pkg::CMP_W-1:0] ROOT_MAX =
		qrs_pkg::CMP_W'((64'd1 << (qrs_pkg::ROOT_W - 1)) - 64'd1);

	logic en;

	logic                                     v_s1;
	logic signed [qrs_pkg::COEF_BITS-1:0]     a_s1;
	logic signed [qrs_pkg::COEF_BITS-1:0]     b_s1;
	logic signed [2*qrs_pkg::COEF_BITS-1:0]   bb_s1;
	logic signed [2*qrs_pkg::COEF_BITS-1:0]   ac_s1;

	logic signed [qrs_pkg::DISC_W-1:0]        disc;
	logic signed [qrs_pkg::DEN_W-1:0]         a2;
	qrs_pkg::sq_t                             sq_first;

	logic          sq_v [qrs_pkg::SQ_STEPS+1];
	qrs_pkg::sq_t  sq_d [qrs_pkg::SQ_STEPS+1];

	logic signed [qrs_pkg::NUM_W-1:0]         nb;
	logic signed [qrs_pkg::NUM_W-1:0]         s_ext;
	logic                                     v_s3;
	logic signed [qrs_pkg::NUM_W-1:0]         nump_s3;
	logic signed [qrs_pkg::NUM_W-1:0]         numm_s3;
	qrs_pkg::side_t                           side_s3;
	qrs_pkg::dv_t                             dv_first;

	logic          dv_v [qrs_pkg::NUM_W+1];
	qrs_pkg::dv_t  dv_d [qrs_pkg::NUM_W+1];

	logic                               out_v_q;
	qrs_pkg::status_t                   status_q;
	logic [qrs_pkg::ROOT_W-1:0]         rp_q;
	logic [qrs_pkg::ROOT_W-1:0]         rm_q;
	qrs_pkg::dv_t                       dv_last;
	logic                               real_last;

	function automatic logic [qrs_pkg::ROOT_W-1:0] sat_root(
		input logic [qrs_pkg::NUM_W-1:0] q,
		input logic                      neg
	);
		logic [qrs_pkg::CMP_W-1:0] qx;
		logic [qrs_pkg::CMP_W-1:0] qn;
		logic [qrs_pkg::ROOT_W-1:0] r;
		qx = qrs_pkg::CMP_W'(q);
		qn = -qx;
		if (neg) begin
			if (qx > ROOT_MAX + 1'b1) begin
				r = {1'b1, {(qrs_pkg::ROOT_W-1){1'b0}}};
			end else begin
				r = qn[qrs_pkg::ROOT_W-1:0];
			end
		end else begin
			if (qx > ROOT_MAX) begin
				r = ROOT_MAX[qrs_pkg::ROOT_W-1:0];
			end else begin
				r = qx[qrs_pkg::ROOT_W-1:0];
			end
		end
		return r;
	endfunction

	assign en            = root_out.ready || !out_v_q;
	assign coef_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= coef_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_in.coef_a;
			b_s1  <= coef_in.coef_b;
			bb_s1 <= coef_in.coef_b * coef_in.coef_b;
			ac_s1 <= coef_in.coef_a * coef_in.coef_c;
		end
	end

	always_comb begin
		disc = qrs_pkg::DISC_W'(bb_s1) - (qrs_pkg::DISC_W'(ac_s1) <<< 2);
		a2   = qrs_pkg::DEN_W'(a_s1) <<< 1;
		sq_first      = '0;
		sq_first.rad  = qrs_pkg::RAD_W'(disc[qrs_pkg::DISC_W-2:0]) << (2 * qrs_pkg::FRAC_BITS);
		sq_first.side.b     = b_s1;
		sq_first.side.a_neg = a_s1[qrs_pkg::COEF_BITS-1];
		sq_first.side.den   = a_s1[qrs_pkg::COEF_BITS-1] ? -a2 : a2;
		if (a_s1 == '0) begin
			sq_first.side.status = qrs_pkg::ST_AZERO;
		end else if (disc[qrs_pkg::DISC_W-1]) begin
			sq_first.side.status = qrs_pkg::ST_IMAG;
		end else begin
			sq_first.side.status = qrs_pkg::ST_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_d[0] <= sq_first;
		end
	end

	for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (sq_v[k]),
			.d_in  (sq_d[k]),
			.v_out (sq_v[k+1]),
			.d_out (sq_d[k+1])
		);
	end

	always_comb begin
		nb    = -(qrs_pkg::NUM_W'(sq_d[qrs_pkg::SQ_STEPS].side.b) <<< qrs_pkg::FRAC_BITS);
		s_ext = qrs_pkg::NUM_W'({1'b0, sq_d[qrs_pkg::SQ_STEPS].root});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v[qrs_pkg::SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nump_s3 <= nb + s_ext;
			numm_s3 <= nb - s_ext;
			side_s3 <= sq_d[qrs_pkg::SQ_STEPS].side;
		end
	end

	always_comb begin
		dv_first        = '0;
		dv_first.status = side_s3.status;
		dv_first.den    = side_s3.den;
		dv_first.neg_p  = nump_s3[qrs_pkg::NUM_W-1] ^ side_s3.a_neg;
		dv_first.neg_m  = numm_s3[qrs_pkg::NUM_W-1] ^ side_s3.a_neg;
		dv_first.lp.acc = nump_s3[qrs_pkg::NUM_W-1] ? -nump_s3 : nump_s3;
		dv_first.lm.acc = numm_s3[qrs_pkg::NUM_W-1] ? -numm_s3 : numm_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d[0] <= dv_first;
		end
	end

	for (genvar k = 0; k < qrs_pkg::NUM_W; k++) begin : g_dv
		qrs_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (dv_v[k]),
			.d_in  (dv_d[k]),
			.v_out (dv_v[k+1]),
			.d_out (dv_d[k+1])
		);
	end

	assign dv_last   = dv_d[qrs_pkg::NUM_W];
	assign real_last = (dv_last.status == qrs_pkg::ST_REAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v[qrs_pkg::NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= dv_last.status;
			rp_q     <= real_last ? sat_root(dv_last.lp.acc, dv_last.neg_p) : '0;
			rm_q     <= real_last ? sat_root(dv_last.lm.acc, dv_last.neg_m) : '0;
		end
	end

	assign root_out.valid      = out_v_q;
	assign root_out.status     = status_q;
	assign root_out.root_plus  = rp_q;
	assign root_out.root_minus = rm_q;

	a_nonreal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q != qrs_pkg::ST_REAL) |-> (rp_q == '0 && rm_q == '0))
		else $error("nonreal status with nonzero root");

	a_azero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_v[0] && sq_d[0].side.status == qrs_pkg::ST_AZERO) |-> (sq_d[0].side.den == '0))
		else $error("zero a status with nonzero divisor");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && dv_v[qrs_pkg::NUM_W]) |=> dv_v[qrs_pkg::NUM_W])
		else $error("divider chain advanced during stall");

endmodule

[hw/rtl/qrs_sqrt_cell.sv]
// One digit cell of the pipelined square root chain.
module qrs_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  qrs_pkg::sq_t   d_in,
	output logic           v_out,
	output qrs_pkg::sq_t   d_out
);

	logic [qrs_pkg::REM_W-1:0] rem_sh;
	logic [qrs_pkg::REM_W-1:0] trial;
	logic                      ge;
	qrs_pkg::sq_t              nxt;
	logic                      v_q;
	qrs_pkg::sq_t              d_q;

	always_comb begin
		rem_sh = {d_in.rem[qrs_pkg::REM_W-3:0], d_in.rad[qrs_pkg::RAD_W-1 -: 2]};
		trial  = {d_in.root, 2'b01};
		ge     = (rem_sh >= trial);
		nxt      = d_in;
		nxt.rad  = {d_in.rad[qrs_pkg::RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
		nxt.root = {d_in.root[qrs_pkg::SQ_STEPS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign v_out = v_q;
	assign d_out = d_q;

endmodule

[hw/rtl/qrs_div_cell.sv]
// One quotient bit cell of the pipelined two-lane restoring divider.
module qrs_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  qrs_pkg::dv_t   d_in,
	output logic           v_out,
	output qrs_pkg::dv_t   d_out
);

	logic [qrs_pkg::DEN_W:0] sh_p;
	logic [qrs_pkg::DEN_W:0] sh_m;
	logic [qrs_pkg::DEN_W:0] den_x;
	logic                    ge_p;
	logic                    ge_m;
	qrs_pkg::dv_t            nxt;
	logic                    v_q;
	qrs_pkg::dv_t            d_q;

	always_comb begin
		den_x = {1'b0, d_in.den};
		sh_p  = {d_in.lp.rem, d_in.lp.acc[qrs_pkg::NUM_W-1]};
		sh_m  = {d_in.lm.rem, d_in.lm.acc[qrs_pkg::NUM_W-1]};
		ge_p  = (sh_p >= den_x);
		ge_m  = (sh_m >= den_x);
		nxt        = d_in;
		nxt.lp.rem = ge_p ? qrs_pkg::DEN_W'(sh_p - den_x) : qrs_pkg::DEN_W'(sh_p);
		nxt.lm.rem = ge_m ? qrs_pkg::DEN_W'(sh_m - den_x) : qrs_pkg::DEN_W'(sh_m);
		nxt.lp.acc = {d_in.lp.acc[qrs_pkg::NUM_W-2:0], ge_p};
		nxt.lm.acc = {d_in.lm.acc[qrs_pkg::NUM_W-2:0], ge_m};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign v_out = v_q;
	assign d_out = d_q;

endmodule
